// File: src/tkeg_pkg.sv
// Package for the touch key event generator: payload structs, event codes,
// register indexes, control and status bundles, controller state type.
// No dependencies.
package tkeg_pkg;

  // fixed field widths
  localparam int FLAG_W    = 12;
  localparam int MS_W      = 16;
  localparam int KEY_W     = 4;
  localparam int KIND_W    = 2;
  localparam int COUNT_W   = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // default key count
  localparam int KEY_COUNT_DEF = 12;

  // register reset values
  localparam logic [MS_W-1:0] REPEAT_DELAY_RST  = MS_W'(500);
  localparam logic [MS_W-1:0] DOUBLE_WINDOW_RST = MS_W'(250);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_DELAY  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_DOUBLE_WINDOW = CFG_ADDR_W'(1);

  // event kinds
  localparam logic [KIND_W-1:0] EV_PRESSED  = KIND_W'(0);
  localparam logic [KIND_W-1:0] EV_DOUBLE   = KIND_W'(1);
  localparam logic [KIND_W-1:0] EV_REPEATED = KIND_W'(2);
  localparam logic [KIND_W-1:0] EV_RELEASED = KIND_W'(3);

  typedef struct packed {
    logic [FLAG_W-1:0] touch_flags;
    logic [MS_W-1:0]   elapsed_ms;
  } tkeg_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_index;
    logic [KIND_W-1:0]  event_kind;
    logic [COUNT_W-1:0] repeat_count;
    logic               last_event;
  } tkeg_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // take a new sample, bump the timer
    logic step;    // evaluate the current key and advance
    logic flush;   // move the held event to the output as final
    logic finish;  // sample done, remember its flags
  } tkeg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ev;          // current key produces an event
    logic last_key;    // current key is the last one scanned
    logic pend_valid;  // an event is held back
    logic out_free;    // output register can take a word this cycle
  } tkeg_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } tkeg_state_t;

endpackage

// File: src/touch_key_event_generator.sv
// Top level of the touch key event generator: controller plus datapath.
// Depends on tkeg_pkg, tkeg_ctrl, tkeg_dp.
//
// Usage: in_word carries one touch sample (one flag per key) and the
// milliseconds since the previous sample, taken on in_valid && in_ready.
// The block then scans keys 0 upward, one key per cycle while not stalled,
// and sends one out_word per pressed, double pressed, repeated or released
// key, in key order; last_event marks the final word of a sample. A sample
// with no event gives no word.
// Each event is held back one slot until the next event or the end of the
// scan shows whether it is the last; the event that releases it loads it
// into the output register. A sample passes a load, a scan of
// min(KEY_COUNT, 12) keys and a final flush when the receiver keeps up.
// in_ready is high only between samples, and may be high while a final
// word still waits in the output register.
// When the receiver stalls, the scan halts at the next event that would
// need the occupied output register and resumes once it drains; the final
// word waits the same way before the block goes idle.
// Reset (rst, synchronous) clears flags, timer and repeat count and loads
// a repeat delay of 500 ms and a double press window of 250 ms. cfg_we,
// cfg_addr, cfg_data write the registers; the user must do so only while
// idle, since the block itself does not enforce it.
module touch_key_event_generator
  import tkeg_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tkeg_in_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tkeg_out_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tkeg_cmd_t    cmd;
  tkeg_status_t status;

  tkeg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tkeg_dp #(
    .KEY_COUNT (KEY_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// File: src/tkeg_ctrl.sv
// Controller for the touch key event generator: sequences load, key scan
// and final flush. Depends on tkeg_pkg.
module tkeg_ctrl
  import tkeg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tkeg_status_t status,
  output tkeg_cmd_t    cmd
);

  tkeg_state_t state;
  tkeg_state_t state_next;
  logic        stall;

  // a new event cannot displace the held one while the output is full
  assign stall = status.ev && status.pend_valid && !status.out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall && status.last_key) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.step = !stall;
      end
      ST_FLUSH: begin
        cmd.flush  = status.pend_valid && status.out_free;
        cmd.finish = !status.pend_valid || status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: src/tkeg_dp.sv
// Datapath for the touch key event generator: config registers, shared
// timer, repeat counter, key scan, held event and output register.
// Depends on tkeg_pkg.
module tkeg_dp
  import tkeg_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tkeg_in_t              in_word,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  tkeg_cmd_t             cmd,
  output tkeg_status_t          status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tkeg_out_t             out_word
);

  // keys past the touch bits never give events
  localparam int SCAN_KEYS = (KEY_COUNT < FLAG_W) ? KEY_COUNT : FLAG_W;
  localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(SCAN_KEYS - 1);

  logic [MS_W-1:0]    repeat_delay;
  logic [MS_W-1:0]    double_window;
  logic [FLAG_W-1:0]  prev_flags;
  logic [FLAG_W-1:0]  cur_flags;
  logic [MS_W-1:0]    timer;
  logic [COUNT_W-1:0] counter;
  logic [KEY_W-1:0]   key;
  logic               pend_valid;
  tkeg_out_t          pend_word;

  logic [MS_W:0]      timer_sum;
  logic               is_on;
  logic               was_on;
  logic               ev;
  logic [KIND_W-1:0]  ev_kind;
  logic [MS_W-1:0]    timer_next;
  logic [COUNT_W-1:0] counter_next;
  logic               out_free;
  logic               push;
  tkeg_out_t          push_word;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay  <= REPEAT_DELAY_RST;
      double_window <= DOUBLE_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_REPEAT_DELAY:  repeat_delay  <= cfg_data;
        CFG_DOUBLE_WINDOW: double_window <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturating timer update on load
  assign timer_sum = {1'b0, timer} + {1'b0, in_word.elapsed_ms};

  // per key event decision
  assign is_on  = cur_flags[key];
  assign was_on = prev_flags[key];

  always_comb begin
    ev           = 1'b0;
    ev_kind      = EV_PRESSED;
    timer_next   = timer;
    counter_next = counter;
    if (is_on && !was_on) begin
      ev           = 1'b1;
      ev_kind      = (timer <= double_window) ? EV_DOUBLE : EV_PRESSED;
      timer_next   = '0;
      counter_next = '0;
    end else if (is_on && was_on) begin
      if (timer >= repeat_delay) begin
        ev           = 1'b1;
        ev_kind      = EV_REPEATED;
        timer_next   = '0;
        counter_next = counter + COUNT_W'(1);
      end
    end else if (!is_on && was_on) begin
      ev           = 1'b1;
      ev_kind      = EV_RELEASED;
      counter_next = '0;
    end
  end

  // output handoff: held event leaves when a newer one arrives or at the end
  assign out_free = !out_valid || out_ready;
  assign push     = (cmd.step && ev && pend_valid) || cmd.flush;

  always_comb begin
    push_word            = pend_word;
    push_word.last_event = cmd.flush;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_flags <= '0;
      timer      <= '0;
      counter    <= '0;
      key        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        timer <= timer_sum[MS_W] ? {MS_W{1'b1}} : timer_sum[MS_W-1:0];
        key   <= '0;
      end
      if (cmd.step) begin
        timer   <= timer_next;
        counter <= counter_next;
        if (key != LAST_KEY) key <= key + KEY_W'(1);
        if (ev) pend_valid <= 1'b1;
      end
      if (cmd.flush) pend_valid <= 1'b0;
      if (cmd.finish) prev_flags <= cur_flags;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) cur_flags <= in_word.touch_flags;
    if (cmd.step && ev) begin
      pend_word.key_index    <= key;
      pend_word.event_kind   <= ev_kind;
      pend_word.repeat_count <= counter_next;
      pend_word.last_event   <= 1'b0;
    end
    if (push) out_word <= push_word;
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.ev         = ev;
  assign status.last_key   = (key == LAST_KEY);
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;

endmodule

// File: src/tkeg_checker.sv
// Port level checks for the touch key event generator, bound to the top.
// Depends on tkeg_pkg and touch_key_event_generator.
module tkeg_checker
  import tkeg_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input tkeg_out_t out_word
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // after reset the block is empty and takes a sample
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // an accepted sample keeps the input closed while it is scanned
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a sample");

  // events only come from existing keys
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.key_index < KEY_W'(FLAG_W))
    else $error("event from a key past the touch flags");

endmodule

bind touch_key_event_generator tkeg_checker u_tkeg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// File: test/tb_touch_key_event_generator.sv
// Testbench for touch_key_event_generator: directed stimulus table, then random
// phases under several register settings, every event word checked in order.
// Depends on tkeg_pkg and the touch_key_event_generator RTL.
`timescale 1ns / 1ps

module tb_touch_key_event_generator;
  import tkeg_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 2;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_NS    = 3_000_000;
  localparam int KEYS          = KEY_COUNT_DEF;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 18;
  localparam int HOLD_ITEMS    = 12;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = CFG_ADDR_W'(3);

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  tkeg_in_t              in_word  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tkeg_out_t             out_word;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_REPEAT_DELAY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted block state and registers
  logic [FLAG_W-1:0]  flags_prev   = '0;
  logic [MS_W-1:0]    shared_timer = '0;
  logic [COUNT_W-1:0] rep_count    = '0;
  logic [MS_W-1:0]    delay_reg    = REPEAT_DELAY_RST;
  logic [MS_W-1:0]    window_reg   = DOUBLE_WINDOW_RST;

  tkeg_out_t events_due[$];
  tkeg_out_t sample_events[$];

  int mismatches    = 0;
  int samples_sent  = 0;
  int words_checked = 0;
  int settings_used = 1;
  int kind_count[4] = '{0, 0, 0, 0};
  int burst_left    = 0;
  bit hold_req      = 1'b0;

  typedef struct {
    bit                cfg_change;
    logic [MS_W-1:0]   delay;
    logic [MS_W-1:0]   window;
    logic [FLAG_W-1:0] flags;
    logic [MS_W-1:0]   ms;
    bit                typed;
    tkeg_out_t         word;
  } dir_row_t;

  dir_row_t dir_rows[$];

  touch_key_event_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("FAIL");
    $finish;
  end

  // event prediction for one sample, fills sample_events in key order
  function automatic void predict_events(input tkeg_in_t w);
    logic [MS_W:0] sum;
    tkeg_out_t     ev;
    sample_events.delete();
    sum = {1'b0, shared_timer} + {1'b0, w.elapsed_ms};
    shared_timer = sum[MS_W] ? '1 : sum[MS_W-1:0];
    for (int k = 0; k < KEYS; k++) begin
      ev.key_index  = KEY_W'(k);
      ev.last_event = 1'b0;
      if (w.touch_flags[k] && !flags_prev[k]) begin
        ev.event_kind   = (shared_timer <= window_reg) ? EV_DOUBLE : EV_PRESSED;
        rep_count       = '0;
        shared_timer    = '0;
        ev.repeat_count = rep_count;
        sample_events.push_back(ev);
      end else if (w.touch_flags[k] && flags_prev[k]) begin
        // held key, repeats only once the shared timer reaches the delay
        if (shared_timer >= delay_reg) begin
          rep_count       = rep_count + COUNT_W'(1);
          shared_timer    = '0;
          ev.event_kind   = EV_REPEATED;
          ev.repeat_count = rep_count;
          sample_events.push_back(ev);
        end
      end else if (!w.touch_flags[k] && flags_prev[k]) begin
        rep_count       = '0;
        ev.event_kind   = EV_RELEASED;
        ev.repeat_count = rep_count;
        sample_events.push_back(ev);
      end
    end
    if (sample_events.size() != 0) begin
      ev = sample_events.pop_back();
      ev.last_event = 1'b1;
      sample_events.push_back(ev);
    end
    flags_prev = w.touch_flags;
  endfunction

  function automatic void add_row(input logic [FLAG_W-1:0] f, input logic [MS_W-1:0] ms,
                                  input bit typed = 1'b0, input tkeg_out_t w = '0);
    dir_row_t r;
    r.cfg_change = 1'b0;
    r.delay      = '0;
    r.window     = '0;
    r.flags      = f;
    r.ms         = ms;
    r.typed      = typed;
    r.word       = w;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [MS_W-1:0] delay, input logic [MS_W-1:0] window);
    dir_row_t r;
    r = '{1'b1, delay, window, '0, '0, 1'b0, '0};
    dir_rows.push_back(r);
  endfunction

  // mostly holds, single presses and releases, some noise
  function automatic logic [FLAG_W-1:0] pick_flags(input logic [FLAG_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return FLAG_W'($urandom);
      1:       return '0;
      2:       return '1;
      3, 4:    return prev;
      5:       return prev ^ (FLAG_W'(1) << $urandom_range(0, FLAG_W - 1))
                           ^ (FLAG_W'(1) << $urandom_range(0, FLAG_W - 1));
      default: return prev ^ (FLAG_W'(1) << $urandom_range(0, FLAG_W - 1));
    endcase
  endfunction

  function automatic logic [MS_W-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return MS_W'($urandom);
      default: return MS_W'($urandom_range(0, 400));
    endcase
  endfunction

  // offer one sample in bursts, predict once accepted
  task automatic send_sample(input logic [FLAG_W-1:0] f, input logic [MS_W-1:0] ms,
                             input bit typed = 1'b0, input tkeg_out_t w = '0);
    tkeg_in_t word;
    word.touch_flags = f;
    word.elapsed_ms  = ms;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= word;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    predict_events(word);
    if (typed) begin
      events_due.push_back(w);
    end else begin
      foreach (sample_events[j]) events_due.push_back(sample_events[j]);
    end
  endtask

  // wait until every expected word is out and the scan has finished
  task automatic drain();
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [MS_W-1:0] delay, input logic [MS_W-1:0] window);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_REPEAT_DELAY;
    cfg_data <= delay;
    @(posedge clk);
    cfg_addr <= CFG_DOUBLE_WINDOW;
    cfg_data <= window;
    @(posedge clk);
    cfg_addr <= CFG_SPARE_A;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_addr <= CFG_SPARE_B;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we     <= 1'b0;
    delay_reg  = delay;
    window_reg = window;
    settings_used++;
  endtask

  // receiver: rotating ready pattern, one long hold-off on request
  initial begin : receiver
    logic [7:0] pattern;
    int         pat_left;
    int         hold_left;
    pattern   = 8'hFF;
    pat_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
      end else begin
        if (pat_left == 0) begin
          pattern  = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
          pat_left = $urandom_range(16, 64);
        end
        out_ready <= pattern[0];
        pattern   = {pattern[0], pattern[7:1]};
        pat_left--;
      end
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin : check_words
    tkeg_out_t exp_ev;
    if (!rst && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: key %0d kind %0d count %0d last %0b",
                   out_word.key_index, out_word.event_kind, out_word.repeat_count,
                   out_word.last_event);
      end else begin
        exp_ev = events_due.pop_front();
        words_checked++;
        kind_count[exp_ev.event_kind]++;
        if (out_word.key_index !== exp_ev.key_index ||
            out_word.event_kind !== exp_ev.event_kind ||
            out_word.repeat_count !== exp_ev.repeat_count ||
            out_word.last_event !== exp_ev.last_event) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: expected key %0d kind %0d count %0d last %0b,",
                      " got key %0d kind %0d count %0d last %0b"},
                     exp_ev.key_index, exp_ev.event_kind, exp_ev.repeat_count,
                     exp_ev.last_event, out_word.key_index, out_word.event_kind,
                     out_word.repeat_count, out_word.last_event);
        end
      end
    end
  end

  initial begin : stimulus
    logic [MS_W-1:0]   delay;
    logic [MS_W-1:0]   window;
    logic [FLAG_W-1:0] flags;

    // directed table, reset register values first
    add_row(12'h000, 16'd0);
    add_row(12'h001, 16'd0, 1'b1, tkeg_out_t'{4'd0, EV_DOUBLE, 16'd0, 1'b1});
    add_row(12'h001, 16'hFFFF, 1'b1, tkeg_out_t'{4'd0, EV_REPEATED, 16'd1, 1'b1});
    add_row(12'h001, 16'd100);
    // timer saturates instead of wrapping
    add_row(12'h001, 16'hFFFF, 1'b1, tkeg_out_t'{4'd0, EV_REPEATED, 16'd2, 1'b1});
    add_row(12'h000, 16'd0, 1'b1, tkeg_out_t'{4'd0, EV_RELEASED, 16'd0, 1'b1});
    // all keys at once, shared timer cleared by the first press
    add_row(12'hFFF, 16'hFFFF);
    // held just below the repeat delay
    add_row(12'hFFF, 16'd499);
    add_row(12'hFFF, 16'd1, 1'b1, tkeg_out_t'{4'd0, EV_REPEATED, 16'd1, 1'b1});
    add_row(12'h800, 16'd300);
    add_row(12'hAAA, 16'd251);
    add_row(12'h555, 16'd250);
    // zero repeat delay, held keys repeat every sample
    add_cfg(16'd0, 16'd0);
    add_row(12'h555, 16'd0);
    add_row(12'h555, 16'd0);
    add_row(12'h000, 16'd0);
    add_row(12'h001, 16'd0, 1'b1, tkeg_out_t'{4'd0, EV_DOUBLE, 16'd0, 1'b1});
    add_row(12'h003, 16'd1);
    add_cfg(16'hFFFF, 16'hFFFF);
    add_row(12'h003, 16'hFFFF, 1'b1, tkeg_out_t'{4'd0, EV_REPEATED, 16'd1, 1'b1});
    add_row(12'hFFC, 16'hFFFF);
    add_row(12'h000, 16'd0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_change) begin
        drain();
        set_regs(dir_rows[i].delay, dir_rows[i].window);
      end else begin
        send_sample(dir_rows[i].flags, dir_rows[i].ms, dir_rows[i].typed, dir_rows[i].word);
      end
    end

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          delay  = REPEAT_DELAY_RST;
          window = DOUBLE_WINDOW_RST;
        end
        1: begin
          delay  = MS_W'($urandom_range(0, 600));
          window = MS_W'($urandom_range(0, 600));
        end
        2: begin
          delay  = '0;
          window = MS_W'($urandom_range(0, 300));
        end
        3: begin
          delay  = MS_W'($urandom);
          window = MS_W'($urandom);
        end
        default: begin
          delay  = MS_W'(1);
          window = '1;
        end
      endcase
      drain();
      set_regs(delay, window);
      // receiver holds off while full-width toggles fill the block
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) drain();
        if (p == 0 && i < HOLD_ITEMS)
          flags = (i % 2 == 0) ? 12'hFFF : 12'h000;
        else
          flags = pick_flags(flags_prev);
        send_sample(flags, pick_elapsed());
      end
    end

    drain();
    $display("covered %0d samples, %0d event words (%0d pressed, %0d double,",
             samples_sent, words_checked, kind_count[EV_PRESSED], kind_count[EV_DOUBLE]);
    $display("%0d repeated, %0d released), %0d register settings, %0d mismatches",
             kind_count[EV_REPEATED], kind_count[EV_RELEASED], settings_used, mismatches);
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tkeg_pkg.sv
src/tkeg_ctrl.sv
src/tkeg_dp.sv
src/touch_key_event_generator.sv
src/tkeg_checker.sv
test/tb_touch_key_event_generator.sv
